// ===== rtl/u8v_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types, codes and constants of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

  // Byte classes found by the front stage
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_e;

  // One classified beat; bits holds the payload bits of a lead or
  // continuation byte, already masked
  typedef struct packed {
    byte_cls_e  cls;
    logic [5:0] bits;
    logic       last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  // Result status codes
  localparam logic [1:0] ST_FINE     = 2'd0;
  localparam logic [1:0] ST_VALID    = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [31:0] MAX_LEN_RST = 32'd16777216;
  localparam int          QUEUE_DEPTH = 2;

  localparam logic [20:0] CODE_MAX = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;
  localparam logic [16:0] MIN_2B   = 17'h00080;
  localparam logic [16:0] MIN_3B   = 17'h00800;
  localparam logic [16:0] MIN_4B   = 17'h10000;

endpackage
`default_nettype wire

// ===== rtl/utf8_stream_validator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// Streaming UTF-8 validator with a configurable maximum text length.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tdata[7:0] data byte, tlast marks the last byte of a text
//  m_axis    out  tdata[1:0] status (upper bits zero), tuser final verdict
//  cfg_w     in   wdata[31:0] maximum text length in bytes
//
//  One byte per cycle sustained while m_axis is ready. A byte is held in
//  the input register, then in the queue, and is decoded into the output
//  register as it leaves the queue.
//  Reset clears all control state and loads a maximum length of 2^24.
//  A stalled m_axis only fills the queue; the input side keeps taking bytes
//  until the queue and input register are full.
//
module utf8_stream_validator_core #(
  parameter int QueueDepth = u8v_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream: tdata = data_byte[7:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // master stream: tdata = status[1:0], zero fill [7:2]; tuser = final_res
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tuser,
  // configuration write channel: max_length
  input  wire logic        cfg_wvalid_i,
  output logic             cfg_wready_o,
  input  wire logic [31:0] cfg_wdata_i
);
  import u8v_pkg::*;

  localparam int ItemW = $bits(item_t);

  logic        max_len_wr;
  logic [31:0] max_len_q;

  logic        fr_valid;
  logic        fr_ready;
  item_t       fr_item;

  fifo_st_t    q_st;
  logic        q_pop;
  item_t       q_item;
  logic [ItemW-1:0] q_data;

  logic [1:0]  res_status;

  // Config must only be written while idle; the block does not enforce this and always takes the write
  assign cfg_wready_o = 1'b1;
  assign max_len_wr   = cfg_wvalid_i && cfg_wready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
    end else if (max_len_wr) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // Front: classify each byte and hold it until the queue takes it
  u8v_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  assign fr_ready = !q_st.full;

  // Queue: decouple classification from decode
  u8v_fifo #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_valid),
    .push_data_i (fr_item),
    .pop_i       (q_pop),
    .pop_data_o  (q_data),
    .status_o    (q_st)
  );

  assign q_item = item_t'(q_data);

  // Back: advance the decoder and register one result per byte
  u8v_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_len_i    (max_len_q),
    .in_valid_i   (!q_st.empty),
    .in_pop_o     (q_pop),
    .in_item_i    (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (res_status),
    .out_final_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, res_status};

  // Queue can never read full and empty at once
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_st.full && q_st.empty))
    else $error("queue reports full and empty together");

  // Every decoded byte shows up as a result on the next cycle
  a_pop_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid)
    else $error("decoded byte did not reach the output register");

  // Results before the text end never carry a verdict
  a_mid_fine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (res_status == ST_FINE))
    else $error("verdict on a non-final result");

  // A final result always carries a verdict
  a_final_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (res_status != ST_FINE))
    else $error("final result without a verdict");

endmodule
`default_nettype wire

// ===== rtl/u8v_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_front
// Input stage: take byte beats, classify them and hold one classified beat.
// ----------------------------------------------------------------------------
module u8v_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic           in_last_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output u8v_pkg::item_t      out_item_o
);
  import u8v_pkg::*;

  logic  valid_q;
  item_t item_q;
  item_t item_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    item_d.last = in_last_i;
    item_d.bits = 6'd0;
    if (in_byte_i inside {[8'h00:8'h7F]}) begin
      item_d.cls = CLS_ASCII;
    end else if (in_byte_i inside {[8'h80:8'hBF]}) begin
      item_d.cls  = CLS_CONT;
      item_d.bits = in_byte_i[5:0];
    end else if (in_byte_i inside {[8'hC0:8'hDF]}) begin
      item_d.cls  = CLS_LEAD2;
      item_d.bits = {1'b0, in_byte_i[4:0]};
    end else if (in_byte_i inside {[8'hE0:8'hEF]}) begin
      item_d.cls  = CLS_LEAD3;
      item_d.bits = {2'b0, in_byte_i[3:0]};
    end else if (in_byte_i inside {[8'hF0:8'hF7]}) begin
      item_d.cls  = CLS_LEAD4;
      item_d.bits = {3'b0, in_byte_i[2:0]};
    end else begin
      item_d.cls = CLS_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/u8v_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_fifo
// Short register queue between the front and back stages.
// ----------------------------------------------------------------------------
module u8v_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      pop_data_o,
  output u8v_pkg::fifo_st_t     status_o
);
  import u8v_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/u8v_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_back
// Decode stage: track sequences, count bytes and register the verdict.
// ----------------------------------------------------------------------------
module u8v_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [31:0]    max_len_i,
  input  wire logic           in_valid_i,
  output logic                in_pop_o,
  input  wire u8v_pkg::item_t in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          out_status_o,
  output logic                out_final_o
);
  import u8v_pkg::*;

  logic [1:0]  left_q, left_d;
  logic [20:0] acc_q, acc_d;
  logic [16:0] min_q, min_d;
  logic        bad_q, bad_d;
  logic [31:0] cnt_q, cnt_d;
  logic        ovalid_q;
  logic [1:0]  status_q, status_d;
  logic        final_q;
  logic        too_long;
  logic [20:0] acc_shift;

  assign in_pop_o     = in_valid_i && (!ovalid_q || out_ready_i);
  assign out_valid_o  = ovalid_q;
  assign out_status_o = status_q;
  assign out_final_o  = final_q;

  assign too_long  = (cnt_q >= max_len_i);
  assign acc_shift = {acc_q[14:0], in_item_i.bits};

  always_comb begin
    left_d   = left_q;
    acc_d    = acc_q;
    min_d    = min_q;
    bad_d    = bad_q;
    cnt_d    = cnt_q;
    status_d = ST_FINE;
    // Decode only while the text is still clean
    if (!bad_q) begin
      if (left_q == 2'd0) begin
        case (in_item_i.cls)
          CLS_ASCII: ;
          CLS_LEAD2: begin
            left_d = 2'd1;
            acc_d  = {15'd0, in_item_i.bits};
            min_d  = MIN_2B;
          end
          CLS_LEAD3: begin
            left_d = 2'd2;
            acc_d  = {15'd0, in_item_i.bits};
            min_d  = MIN_3B;
          end
          CLS_LEAD4: begin
            left_d = 2'd3;
            acc_d  = {15'd0, in_item_i.bits};
            min_d  = MIN_4B;
          end
          default: bad_d = 1'b1;
        endcase
      end else if (in_item_i.cls != CLS_CONT) begin
        bad_d  = 1'b1;
        left_d = 2'd0;
      end else begin
        acc_d  = acc_shift;
        left_d = left_q - 2'd1;
        if (left_q == 2'd1) begin
          if ((acc_shift < {4'd0, min_q}) || (acc_shift > CODE_MAX) ||
              ((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI))) begin
            bad_d = 1'b1;
          end
        end
      end
    end
    if (in_item_i.last) begin
      if (too_long) begin
        status_d = ST_TOO_LONG;
      end else if (bad_d || (left_d != 2'd0)) begin
        status_d = ST_INVALID;
      end else begin
        status_d = ST_VALID;
      end
      left_d = 2'd0;
      acc_d  = '0;
      min_d  = '0;
      bad_d  = 1'b0;
      cnt_d  = '0;
    end else if (cnt_q != 32'hFFFF_FFFF) begin
      cnt_d = cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      acc_q    <= '0;
      min_q    <= '0;
      bad_q    <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (in_pop_o) begin
        left_q <= left_d;
        acc_q  <= acc_d;
        min_q  <= min_d;
        bad_q  <= bad_d;
        cnt_q  <= cnt_d;
      end
      if (in_pop_o) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      status_q <= status_d;
      final_q  <= in_item_i.last;
    end
  end

endmodule
`default_nettype wire
